FILE: hdl/ple_pkg.sv
// Package: shared types and constants of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_LOCATE = 2'd1,
      MODE_INSERT = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      mode_type                 mode;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  read_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         length;
   } rsp_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic signed [VAL_W-1:0]  value;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/ple_cell.sv
// One list cell: holds a word, shifts with its neighbors, compares against the key.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell
   import ple_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_ctl_type            ctl,
   input  wire logic signed [VAL_W-1:0] lower_data,
   input  wire logic signed [VAL_W-1:0] upper_data,
   output logic signed [VAL_W-1:0]      data_out,
   output logic                         match
);

   logic signed [VAL_W-1:0] data_ff;
   logic signed [VAL_W-1:0] data_in;

   always_comb begin
      case (ctl.cmd)
         CELL_LOAD:       data_in = ctl.value;
         CELL_FROM_LOWER: data_in = lower_data;
         CELL_FROM_UPPER: data_in = upper_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign match    = (data_ff == ctl.value);

endmodule
`default_nettype wire

FILE: hdl/positional_list_engine_top.sv
// Top level: request decode, cell row control and result register of the list engine.
// An accepted item waits in the operation register; its result is registered once the result slot is free.
// Throughput: one item per cycle if results drain; each item is a single pass over the cell row
//   (shift for insert/delete, parallel compare plus first-match encode for locate).
// Reset: synchronous, clears entry count and handshake state; the list is empty at once,
//   cell contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_top
   import ple_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   // Operation holding register and result register.
   logic             op_valid_ff;
   req_type          op_item_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_item_ff;
   rsp_type          rsp_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic fire;

   // Cell row wiring.
   cell_ctl_type            cell_ctl   [CAPACITY];
   logic signed [VAL_W-1:0] cell_data  [CAPACITY];
   logic signed [VAL_W-1:0] lower_data [CAPACITY];
   logic signed [VAL_W-1:0] upper_data [CAPACITY];
   logic [CAPACITY-1:0]     cell_match;

   // Decode helpers.
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] idx_x;
   logic             pos_zero;
   logic             rd_ok;
   logic             ins_ok;
   logic             full;
   logic             do_ins;
   logic             do_del;
   logic             any_match;
   logic [CNT_W-1:0] first_pos;

   // An item moves on when the result slot is free or being emptied.
   assign fire      = op_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !op_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_ready) op_valid_ff <= req_valid;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (fire) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) op_item_ff <= req_item;
      if (fire) rsp_item_ff <= rsp_in;
   end

   // Range checks on the 1-based position.
   always_comb begin
      pos_x    = CMP_W'(op_item_ff.position);
      cnt_x    = CMP_W'(count_ff);
      idx_x    = pos_x - CMP_W'(1);
      pos_zero = (op_item_ff.position == '0);
      rd_ok    = !pos_zero && (pos_x <= cnt_x);
      ins_ok   = !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
      full     = (count_ff == CNT_W'(CAPACITY));
   end

   // First match among occupied cells; scan from the top so the lowest wins.
   always_comb begin
      first_pos = '0;
      any_match = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i] && (CMP_W'(i) < cnt_x)) begin
            first_pos = CNT_W'(i + 1);
            any_match = 1'b1;
         end
      end
   end

   // Operation decode.
   always_comb begin
      rsp_in   = '{status: ST_OK, read_value: '0, found_position: '0, length: '0};
      count_in = count_ff;
      do_ins   = 1'b0;
      do_del   = 1'b0;
      unique case (op_item_ff.mode)
         MODE_READ: begin
            if (rd_ok) rsp_in.read_value = cell_data[idx_x[IDX_W-1:0]];
            else       rsp_in.status     = ST_RANGE;
         end
         MODE_LOCATE: begin
            if (any_match) rsp_in.found_position = POS_W'(first_pos);
            else           rsp_in.status         = ST_MISSING;
         end
         MODE_INSERT: begin
            if (!ins_ok) begin
               rsp_in.status = ST_RANGE;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (rd_ok) begin
               do_del   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         default: rsp_in.status = ST_RANGE;
      endcase
      rsp_in.length = POS_W'(count_in);
   end

   // Per-cell commands: insert opens a slot at the position, delete closes it.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctl[i].value = op_item_ff.value;
         cell_ctl[i].cmd   = CELL_HOLD;
         if (fire && do_ins) begin
            if (CMP_W'(i) > idx_x)       cell_ctl[i].cmd = CELL_FROM_LOWER;
            else if (CMP_W'(i) == idx_x) cell_ctl[i].cmd = CELL_LOAD;
         end else if (fire && do_del) begin
            if (CMP_W'(i) >= idx_x)      cell_ctl[i].cmd = CELL_FROM_UPPER;
         end
      end
   end

   // The cell row; end cells get a zero neighbor.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign lower_data[g] = '0;
      end else begin : g_mid_lo
         assign lower_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper_data[g] = '0;
      end else begin : g_mid_hi
         assign upper_data[g] = cell_data[g+1];
      end

      ple_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .lower_data (lower_data[g]),
         .upper_data (upper_data[g]),
         .data_out   (cell_data[g]),
         .match      (cell_match[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

FILE: test/positional_list_engine_top_test.sv
// Testbench for the positional list engine: random and directed list operations against a predictor.
`timescale 1ns / 1ps
module positional_list_engine_top_test
   import ple_pkg::*;
;

   // Run limit in clock cycles, generous for the slowest legal run of roughly 450 items
   // with the longest sender gaps and the longest receiver stalls.
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 395;
   localparam int LONG_HOLD = 80;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the list contents and length, predicts one
   // result per accepted item and checks results in order.
   // ------------------------------------------------------------------
   class list_scoreboard;
      logic signed [VAL_W-1:0] cells [CAPACITY];
      int                      count;
      rsp_type                 expected_q [$];
      int                      fail_count;

      function new();
         count      = 0;
         fail_count = 0;
      endfunction

      // Apply one accepted request to the mirrored list and queue its result.
      function void note_request(req_type r);
         rsp_type e;
         int      p;
         int      k;
         bit      hit;
         e   = '0;
         p   = int'(r.position);
         hit = 0;
         e.status = ST_OK;
         case (r.mode)
            MODE_READ: begin
               if (p < 1 || p > count) e.status = ST_RANGE;
               else e.read_value = cells[p-1];
            end
            MODE_LOCATE: begin
               for (k = 0; k < count; k++) begin
                  if (!hit && cells[k] == r.value) begin
                     hit              = 1;
                     e.found_position = POS_W'(k + 1);
                  end
               end
               if (!hit) e.status = ST_MISSING;
            end
            MODE_INSERT: begin
               if (p < 1 || p > count + 1) e.status = ST_RANGE;
               else if (count >= CAPACITY) e.status = ST_FULL;
               else begin
                  for (k = count; k >= p; k--) cells[k] = cells[k-1];
                  cells[p-1] = r.value;
                  count++;
               end
            end
            default: begin
               if (p < 1 || p > count) e.status = ST_RANGE;
               else begin
                  for (k = p; k < count; k++) cells[k-1] = cells[k];
                  count--;
               end
            end
         endcase
         e.length = count[POS_W-1:0];
         expected_q.push_back(e);
      endfunction

      // Compare one accepted result with the oldest prediction.
      function void check_result(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("result item with nothing expected: %p", a);
            fail_count++;
            return;
         end
         e = expected_q.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status);
            fail_count++;
         end
         if (a.read_value !== e.read_value) begin
            $error("read_value: expected %0d, actual %0d", e.read_value, a.read_value);
            fail_count++;
         end
         if (a.found_position !== e.found_position) begin
            $error("found_position: expected %0d, actual %0d",
                   e.found_position, a.found_position);
            fail_count++;
         end
         if (a.length !== e.length) begin
            $error("length: expected %0d, actual %0d", e.length, a.length);
            fail_count++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block ports. Every input is known from time zero.
   // ------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   list_scoreboard sb = new();

   // Shared pacing controls: calm_phase turns idling off on both sides,
   // hold_request asks the receiver for one long stall.
   bit calm_phase   = 0;
   bit hold_request = 0;
   int cycle_count  = 0;

   always #5 clock = ~clock;

   positional_list_engine_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Gap length: mostly short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------
   // Receiver. Samples the result channel at each edge (pre-edge values),
   // then decides rsp_ready for the next cycle with a single NBA.
   // The long hold-off is counted here, independent of the sender.
   // ------------------------------------------------------------------
   int hold_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_item);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (calm_phase || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a rising edge; holds valid and payload until the
   // item is taken, then notes it with the scoreboard. Valid is only
   // lowered when a gap follows, so it never gets two NBAs in one step.
   // ------------------------------------------------------------------
   task automatic send_item(req_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(it);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_op(mode_type m, int pos, logic [VAL_W-1:0] val);
      req_type it;
      it.mode     = m;
      it.position = pos[POS_W-1:0];
      it.value    = val;
      send_item(it);
   endtask

   // Lower valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Data word: extremes, a small pool that makes duplicates, or anything.
   function automatic logic [VAL_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 30) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   // Build the next random item from the current mirrored length.
   // Growing phases lean on insert, shrinking phases on delete, so the
   // list swings between empty and full; positions are mostly legal.
   function automatic req_type make_item(bit growing);
      req_type it;
      int      r;
      int      n;
      n = sb.count;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // noise: any mode, any position including out-of-range codes
         it.mode     = mode_type'($urandom_range(0, 3));
         it.position = POS_W'($urandom_range(0, 31));
         it.value    = pick_word();
         return it;
      end
      r = $urandom_range(0, 99);
      if (growing)
         it.mode = (r < 50) ? MODE_INSERT : (r < 70) ? MODE_READ :
                   (r < 85) ? MODE_LOCATE : MODE_DELETE;
      else
         it.mode = (r < 50) ? MODE_DELETE : (r < 65) ? MODE_INSERT :
                   (r < 85) ? MODE_READ : MODE_LOCATE;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // boundary positions: zero and just past either limit
         case ($urandom_range(0, 2))
            0: it.position = '0;
            1: it.position = POS_W'(n + 1);
            default: it.position = POS_W'(n + 2);
         endcase
      end else if (it.mode == MODE_INSERT) begin
         it.position = POS_W'($urandom_range(1, n + 1));
      end else begin
         it.position = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
      end
      // locate mostly asks for a value that is in the list
      if (it.mode == MODE_LOCATE && n > 0 && $urandom_range(0, 99) < 60)
         it.value = sb.cells[$urandom_range(0, n - 1)];
      else
         it.value = pick_word();
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int  sent;
      int  phase_len;
      bit  growing;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation on an empty list, bad positions on each
      // operation, inserts at front, end and middle, extreme values,
      // duplicate locate, missing locate, and deletes at each end.
      send_op(MODE_READ,   1,  32'h0);
      send_op(MODE_READ,   0,  32'h0);
      send_op(MODE_DELETE, 1,  32'h0);
      send_op(MODE_LOCATE, 0,  32'h0);
      send_op(MODE_INSERT, 0,  32'h1);
      send_op(MODE_INSERT, 2,  32'h1);
      send_op(MODE_INSERT, 1,  32'h7FFF_FFFF);
      send_op(MODE_INSERT, 2,  32'h8000_0000);
      send_op(MODE_INSERT, 1,  32'hFFFF_FFFF);
      send_op(MODE_INSERT, 2,  32'h0);
      send_op(MODE_INSERT, 5,  32'h5);
      send_op(MODE_INSERT, 7,  32'h7);
      send_op(MODE_LOCATE, 31, 32'h8000_0000);
      send_op(MODE_INSERT, 1,  32'h7FFF_FFFF);
      send_op(MODE_LOCATE, 0,  32'h7FFF_FFFF);
      send_op(MODE_LOCATE, 3,  32'h0001_2345);
      send_op(MODE_READ,   1,  32'h0);
      send_op(MODE_READ,   6,  32'hFFFF_FFFF);
      send_op(MODE_READ,   7,  32'h0);
      send_op(MODE_READ,   31, 32'h0);
      send_op(MODE_DELETE, 7,  32'h0);
      send_op(MODE_DELETE, 0,  32'h0);
      send_op(MODE_DELETE, 6,  32'h0);
      send_op(MODE_DELETE, 1,  32'h0);
      send_op(MODE_DELETE, 2,  32'h0);

      // Backpressure: the receiver stalls for a long stretch while the
      // sender keeps offering items back to back, so the block fills up
      // and drops req_ready. Then the sender waits for everything.
      calm_phase   = 1;
      hold_request = 1;
      for (int i = 0; i < 30; i++) send_item(make_item(1'b1));
      calm_phase = 0;
      drain_results();

      // Random phases alternating growth and shrinkage; some phases run
      // with no idling at all on either side.
      sent    = 0;
      growing = 1;
      while (sent < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(30, 60);
         calm_phase = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            send_item(make_item(growing));
            sent++;
         end
         growing = !growing;
         // occasional full pause between phases
         if ($urandom_range(0, 2) == 0) drain_results();
      end
      calm_phase = 0;

      // Wind down: all results back, then an idle stretch for stray output.
      drain_results();
      repeat (8) @(posedge clock);

      if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_top.sv
test/positional_list_engine_top_test.sv
